// ----- design/gra_pkg.sv -----
// ----------------------------------------------------------------------------
// gra_pkg: shared types for the Gaussian rational ALU
// Transaction payloads, controller/datapath command and status, job table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gra_pkg;

  // Operation codes of the input transaction
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  // Operand slot file: four inputs, four partial products
  localparam int NSLOT  = 8;
  localparam int SLOT_W = 3;

  localparam logic [SLOT_W-1:0] SL_AR = 3'd0;
  localparam logic [SLOT_W-1:0] SL_AI = 3'd1;
  localparam logic [SLOT_W-1:0] SL_BR = 3'd2;
  localparam logic [SLOT_W-1:0] SL_BI = 3'd3;
  localparam logic [SLOT_W-1:0] SL_P1 = 3'd4;
  localparam logic [SLOT_W-1:0] SL_P2 = 3'd5;
  localparam logic [SLOT_W-1:0] SL_P3 = 3'd6;
  localparam logic [SLOT_W-1:0] SL_P4 = 3'd7;

  localparam int JOB_W = 3;
  localparam logic [JOB_W-1:0] LAST_JOB_ADD = 3'd1;
  localparam logic [JOB_W-1:0] LAST_JOB_MUL = 3'd5;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] a_re_num;
    logic signed [31:0] a_re_den;
    logic signed [31:0] a_im_num;
    logic signed [31:0] a_im_den;
    logic signed [31:0] b_re_num;
    logic signed [31:0] b_re_den;
    logic signed [31:0] b_im_num;
    logic signed [31:0] b_im_den;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_re_num;
    logic [30:0]        res_re_den;
    logic signed [31:0] res_im_num;
    logic [30:0]        res_im_den;
    logic               overflow;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MULA, ST_MULB, ST_MULC, ST_SUM,
    ST_GCD, ST_DIVN, ST_DIVD, ST_FIX, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD, DP_MULA, DP_MULB, DP_MULC, DP_SUM,
    DP_GCD, DP_DIVN, DP_DIVD, DP_FIX, DP_OUT
  } dp_op_t;

  // One rational reduction: x op y -> slot ws
  typedef struct packed {
    logic [SLOT_W-1:0] xs;
    logic [SLOT_W-1:0] ys;
    logic [SLOT_W-1:0] ws;
    logic              add;
    logic              sub;
  } job_t;

  typedef struct packed {
    dp_op_t op;
    job_t   job;
  } cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_last;
  } status_t;

  // Reduction sequence for add/sub and for multiply
  function automatic job_t job_of(input logic mul, input logic sub,
                                  input logic [JOB_W-1:0] idx);
    job_t j;
    j = '{xs: SL_AR, ys: SL_BR, ws: SL_AR, add: 1'b1, sub: sub};
    if (!mul) begin
      if (idx != '0) begin
        j = '{xs: SL_AI, ys: SL_BI, ws: SL_AI, add: 1'b1, sub: sub};
      end
    end else begin
      unique case (idx)
        3'd0: j = '{xs: SL_AR, ys: SL_BR, ws: SL_P1, add: 1'b0, sub: 1'b0};
        3'd1: j = '{xs: SL_AI, ys: SL_BI, ws: SL_P2, add: 1'b0, sub: 1'b0};
        3'd2: j = '{xs: SL_AR, ys: SL_BI, ws: SL_P3, add: 1'b0, sub: 1'b0};
        3'd3: j = '{xs: SL_AI, ys: SL_BR, ws: SL_P4, add: 1'b0, sub: 1'b0};
        3'd4: j = '{xs: SL_P1, ys: SL_P2, ws: SL_AR, add: 1'b1, sub: 1'b1};
        default: j = '{xs: SL_P3, ys: SL_P4, ws: SL_AI, add: 1'b1, sub: 1'b0};
      endcase
    end
    return j;
  endfunction

endpackage

`default_nettype wire

// ----- design/gra_datapath.sv -----
// ----------------------------------------------------------------------------
// gra_datapath: operand slots, shared multiplier, GCD and divider
// Executes one controller command per cycle on the rational being reduced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gra_datapath #(
  parameter int PART_WIDTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire gra_pkg::cmd_t   cmd,
  input  wire gra_pkg::in_t    in_data,
  output gra_pkg::status_t     status,
  output gra_pkg::out_t        out_data
);

  localparam int P  = PART_WIDTH;
  localparam int W  = 2 * P;
  localparam int CW = $clog2(W);
  localparam int KW = $clog2(W) + 1;
  localparam logic [W-1:0] TOP = {{(W-1){1'b0}}, 1'b1} << (P - 1);
  localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

  function automatic logic [P-1:0] mag_of(input logic [P-1:0] v);
    return v[P-1] ? (~v + {{(P-1){1'b0}}, 1'b1}) : v;
  endfunction

  // Slot file (two's complement parts) and result register
  logic [P-1:0] sn_r [gra_pkg::NSLOT];
  logic [P-1:0] sd_r [gra_pkg::NSLOT];
  logic         ovf_r;
  gra_pkg::out_t out_r;

  // Intermediates as sign and magnitude
  logic         t1_neg_r, t2_neg_r, nneg_r, dneg_r;
  logic [W-1:0] t1_mag_r, t2_mag_r, nmag_r, dmag_r;

  // GCD and divider state
  logic [W-1:0]  ga_r, gb_r, gdiv_r, rem_r, quo_r;
  logic [KW-1:0] gk_r;
  logic [CW-1:0] cnt_r;

  logic [P-1:0] xn, xd, yn, yd, ma, mb;
  logic         psign;
  logic [W-1:0] prod;

  // Select operands of the current job
  always_comb begin
    xn = sn_r[cmd.job.xs];
    xd = sd_r[cmd.job.xs];
    yn = sn_r[cmd.job.ys];
    yd = sd_r[cmd.job.ys];
  end

  // Share one multiplier over the three product steps
  always_comb begin
    unique case (cmd.op)
      gra_pkg::DP_MULA: begin
        ma    = mag_of(xn);
        mb    = cmd.job.add ? mag_of(yd) : mag_of(yn);
        psign = xn[P-1] ^ (cmd.job.add ? yd[P-1] : yn[P-1]);
      end
      gra_pkg::DP_MULB: begin
        ma    = mag_of(xd);
        mb    = cmd.job.add ? mag_of(yn) : '0;
        psign = xd[P-1] ^ yn[P-1] ^ cmd.job.sub;
      end
      default: begin
        ma    = mag_of(xd);
        mb    = mag_of(yd);
        psign = xd[P-1] ^ yd[P-1];
      end
    endcase
  end

  assign prod = {{P{1'b0}}, ma} * {{P{1'b0}}, mb};

  // Signed sum of the two cross products
  logic         sum_neg;
  logic [W-1:0] sum_mag;

  always_comb begin
    if (t1_neg_r == t2_neg_r) begin
      sum_neg = t1_neg_r;
      sum_mag = t1_mag_r + t2_mag_r;
    end else if (t1_mag_r >= t2_mag_r) begin
      sum_neg = t1_neg_r;
      sum_mag = t1_mag_r - t2_mag_r;
    end else begin
      sum_neg = t2_neg_r;
      sum_mag = t2_mag_r - t1_mag_r;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
  end

  // Binary GCD result; zero over zero divides by one
  logic [W-1:0] gval, gsel;
  assign gval = (ga_r | gb_r) << gk_r;
  assign gsel = (gval == '0) ? ONE : gval;

  assign status.gcd_done = (ga_r == '0) || (gb_r == '0);
  assign status.div_last = (cnt_r == CW'(W - 1));

  // Restoring divider step
  logic [W:0]   div_sh;
  logic         div_ge;
  logic [W-1:0] rem_nxt, quo_nxt;

  always_comb begin
    div_sh  = {rem_r, quo_r[W-1]};
    div_ge  = div_sh >= {1'b0, gdiv_r};
    rem_nxt = div_ge ? W'(div_sh - {1'b0, gdiv_r}) : div_sh[W-1:0];
    quo_nxt = {quo_r[W-2:0], div_ge};
  end

  // Sign fix and range check of the reduced part
  logic         fix_neg, fix_ovf;
  logic [W-1:0] neg_mag;

  always_comb begin
    fix_neg = (dmag_r == '0) ? nneg_r : (nneg_r ^ dneg_r);
    if (nmag_r == '0) begin
      fix_neg = 1'b0;
    end
    fix_ovf = (fix_neg ? (nmag_r > TOP) : (nmag_r > TOP - ONE)) || (dmag_r > TOP - ONE);
    neg_mag = ~nmag_r + ONE;
  end

  // Execute commands
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      gra_pkg::DP_LOAD: begin
        sn_r[gra_pkg::SL_AR] <= in_data.a_re_num[P-1:0];
        sd_r[gra_pkg::SL_AR] <= in_data.a_re_den[P-1:0];
        sn_r[gra_pkg::SL_AI] <= in_data.a_im_num[P-1:0];
        sd_r[gra_pkg::SL_AI] <= in_data.a_im_den[P-1:0];
        sn_r[gra_pkg::SL_BR] <= in_data.b_re_num[P-1:0];
        sd_r[gra_pkg::SL_BR] <= in_data.b_re_den[P-1:0];
        sn_r[gra_pkg::SL_BI] <= in_data.b_im_num[P-1:0];
        sd_r[gra_pkg::SL_BI] <= in_data.b_im_den[P-1:0];
        ovf_r <= 1'b0;
      end
      gra_pkg::DP_MULA: begin
        t1_mag_r <= prod;
        t1_neg_r <= psign & (prod != '0);
      end
      gra_pkg::DP_MULB: begin
        t2_mag_r <= prod;
        t2_neg_r <= psign & (prod != '0);
      end
      gra_pkg::DP_MULC: begin
        dmag_r <= prod;
        dneg_r <= psign & (prod != '0);
      end
      gra_pkg::DP_SUM: begin
        nmag_r <= sum_mag;
        nneg_r <= sum_neg;
        ga_r   <= sum_mag;
        gb_r   <= dmag_r;
        gk_r   <= '0;
      end
      gra_pkg::DP_GCD: begin
        if (status.gcd_done) begin
          gdiv_r <= gsel;
          quo_r  <= nmag_r;
          rem_r  <= '0;
          cnt_r  <= '0;
        end else if (!ga_r[0] && !gb_r[0]) begin
          ga_r <= ga_r >> 1;
          gb_r <= gb_r >> 1;
          gk_r <= gk_r + 1'b1;
        end else if (!ga_r[0]) begin
          ga_r <= ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_r <= gb_r >> 1;
        end else if (ga_r >= gb_r) begin
          ga_r <= ga_r - gb_r;
        end else begin
          gb_r <= gb_r - ga_r;
        end
      end
      gra_pkg::DP_DIVN: begin
        if (status.div_last) begin
          nmag_r <= quo_nxt;
          quo_r  <= dmag_r;
          rem_r  <= '0;
          cnt_r  <= '0;
        end else begin
          quo_r <= quo_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      gra_pkg::DP_DIVD: begin
        if (status.div_last) begin
          dmag_r <= quo_nxt;
        end else begin
          quo_r <= quo_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      gra_pkg::DP_FIX: begin
        sn_r[cmd.job.ws] <= fix_neg ? neg_mag[P-1:0] : nmag_r[P-1:0];
        sd_r[cmd.job.ws] <= {1'b0, dmag_r[P-2:0]};
        ovf_r <= ovf_r | fix_ovf;
      end
      gra_pkg::DP_OUT: begin
        out_r.res_re_num <= 32'(signed'(sn_r[gra_pkg::SL_AR]));
        out_r.res_re_den <= 31'(sd_r[gra_pkg::SL_AR][P-2:0]);
        out_r.res_im_num <= 32'(signed'(sn_r[gra_pkg::SL_AI]));
        out_r.res_im_den <= 31'(sd_r[gra_pkg::SL_AI][P-2:0]);
        out_r.overflow   <= ovf_r;
      end
      default: begin
      end
    endcase
  end

  assign out_data = out_r;

  // rst_n is consumed by the controller; datapath holds payload only
  logic unused_rst;
  assign unused_rst = rst_n;

endmodule

`default_nettype wire

// ----- design/gra_ctrl.sv -----
// ----------------------------------------------------------------------------
// gra_ctrl: sequencer for the Gaussian rational ALU
// Walks the reduction jobs of one transaction and runs the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gra_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_op,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire gra_pkg::status_t  status,
  output gra_pkg::cmd_t          cmd
);

  gra_pkg::state_t             state_r, state_nxt;
  logic [gra_pkg::JOB_W-1:0]   job_r, job_nxt;
  logic                        mul_r, mul_nxt;
  logic                        sub_r, sub_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [gra_pkg::JOB_W-1:0]   last_job;

  assign last_job  = mul_r ? gra_pkg::LAST_JOB_MUL : gra_pkg::LAST_JOB_ADD;
  assign out_valid = out_valid_r;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gra_pkg::ST_IDLE;
      job_r       <= '0;
      mul_r       <= 1'b0;
      sub_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      mul_r       <= mul_nxt;
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    mul_nxt       = mul_r;
    sub_nxt       = sub_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = 1'b0;
    cmd.op        = gra_pkg::DP_NOP;
    cmd.job       = gra_pkg::job_of(mul_r, sub_r, job_r);
    unique case (state_r)
      gra_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = gra_pkg::DP_LOAD;
          mul_nxt   = in_op[1];
          sub_nxt   = (in_op == gra_pkg::OP_SUB);
          job_nxt   = '0;
          state_nxt = gra_pkg::ST_MULA;
        end
      end
      gra_pkg::ST_MULA: begin
        cmd.op    = gra_pkg::DP_MULA;
        state_nxt = gra_pkg::ST_MULB;
      end
      gra_pkg::ST_MULB: begin
        cmd.op    = gra_pkg::DP_MULB;
        state_nxt = gra_pkg::ST_MULC;
      end
      gra_pkg::ST_MULC: begin
        cmd.op    = gra_pkg::DP_MULC;
        state_nxt = gra_pkg::ST_SUM;
      end
      gra_pkg::ST_SUM: begin
        cmd.op    = gra_pkg::DP_SUM;
        state_nxt = gra_pkg::ST_GCD;
      end
      gra_pkg::ST_GCD: begin
        cmd.op = gra_pkg::DP_GCD;
        if (status.gcd_done) begin
          state_nxt = gra_pkg::ST_DIVN;
        end
      end
      gra_pkg::ST_DIVN: begin
        cmd.op = gra_pkg::DP_DIVN;
        if (status.div_last) begin
          state_nxt = gra_pkg::ST_DIVD;
        end
      end
      gra_pkg::ST_DIVD: begin
        cmd.op = gra_pkg::DP_DIVD;
        if (status.div_last) begin
          state_nxt = gra_pkg::ST_FIX;
        end
      end
      gra_pkg::ST_FIX: begin
        cmd.op = gra_pkg::DP_FIX;
        if (job_r == last_job) begin
          state_nxt = gra_pkg::ST_DONE;
        end else begin
          job_nxt   = job_r + 1'b1;
          state_nxt = gra_pkg::ST_MULA;
        end
      end
      gra_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.op        = gra_pkg::DP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = gra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gra_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/gaussian_rational_alu.sv -----
// ----------------------------------------------------------------------------
// gaussian_rational_alu: reduced add, subtract and multiply of Gaussian
// rationals
// Top level joining the sequencer and the arithmetic datapath.
// ----------------------------------------------------------------------------
// One transaction at a time. Each rational part result goes through one
// reduction: three multiplies on the shared PART_WIDTH multiplier, one signed
// add, a binary GCD at one subtract or shift per cycle (data dependent), two
// restoring divisions by the GCD, then a sign fix. Add and subtract take two
// reductions, multiply six. The next transaction is taken while the previous
// result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_rational_alu #(
  parameter int PART_WIDTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire gra_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output gra_pkg::out_t       out_data
);

  gra_pkg::cmd_t    cmd;
  gra_pkg::status_t status;

  gra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_data.op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  gra_datapath #(
    .PART_WIDTH (PART_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .status   (status),
    .out_data (out_data)
  );

  // Accept only one transaction at a time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // Zero numerator reduces to 0/1 or stays 0/0
  a_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.overflow && out_data.res_re_num == '0
      |-> out_data.res_re_den <= 31'd1)
    else $error("zero numerator not reduced");

  // Zero denominator leaves a unit or zero numerator
  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.overflow && out_data.res_im_den == '0
      |-> out_data.res_im_num == 32'sd1 || out_data.res_im_num == '1 ||
          out_data.res_im_num == '0)
    else $error("zero denominator not reduced");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for gaussian_rational_alu
// Drives add, subtract and multiply transactions in bursts with random gaps,
// stalls the result side on its own pattern (once for a long stretch), and
// checks each result against an exact-arithmetic prediction of the reduced
// Gaussian rational.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Signed exact value: sign plus 64-bit magnitude
typedef struct {
  bit          neg;
  bit [63:0]   mag;
} smag_t;

typedef struct {
  smag_t n;
  smag_t d;
} frac_t;

class gra_scoreboard;
  gra_pkg::out_t pending[$];
  int            errors;
  bit            ovf;

  function new();
    errors = 0;
  endfunction

  // Split a 32-bit field into sign and magnitude
  function smag_t split(bit [31:0] v);
    smag_t r;
    r.neg = v[31];
    r.mag = v[31] ? {32'd0, (~v + 32'd1)} : {32'd0, v};
    if (v == 32'h8000_0000) r.mag = 64'h8000_0000;
    return r;
  endfunction

  function smag_t mul_s(smag_t a, smag_t b);
    smag_t r;
    r.mag = a.mag * b.mag;
    r.neg = (a.neg != b.neg) && (r.mag != 0);
    return r;
  endfunction

  function smag_t add_s(smag_t a, smag_t b);
    smag_t r;
    if (a.neg == b.neg) begin
      r.neg = a.neg; r.mag = a.mag + b.mag;
    end else if (a.mag >= b.mag) begin
      r.neg = a.neg; r.mag = a.mag - b.mag;
    end else begin
      r.neg = b.neg; r.mag = b.mag - a.mag;
    end
    if (r.mag == 0) r.neg = 0;
    return r;
  endfunction

  function bit [63:0] euclid(bit [63:0] a, bit [63:0] b);
    bit [63:0] t;
    while (b != 0) begin
      t = a % b; a = b; b = t;
    end
    return a;
  endfunction

  // Reduce, fix sign, and wrap to field width on overflow
  function frac_t normalize(smag_t n, smag_t d);
    bit [63:0] g;
    bit        neg;
    bit [63:0] w;
    frac_t     r;
    g = euclid(n.mag, d.mag);
    if (g != 0) begin
      n.mag = n.mag / g; d.mag = d.mag / g;
    end
    neg = (d.mag == 0) ? n.neg : (n.neg != d.neg);
    if (n.mag == 0) neg = 0;
    if ((neg ? n.mag > 64'h8000_0000 : n.mag > 64'h7FFF_FFFF) ||
        d.mag > 64'h7FFF_FFFF) begin
      ovf = 1;
      w = neg ? (64'd0 - n.mag) : n.mag;
      n = split(w[31:0]);
      d.mag = d.mag & 64'h7FFF_FFFF;
    end else begin
      n.neg = neg;
    end
    d.neg = 0;
    r.n = n; r.d = d;
    return r;
  endfunction

  function frac_t sum_q(frac_t a, frac_t b, bit minus);
    smag_t bn;
    bn = b.n;
    if (minus && bn.mag != 0) bn.neg = !bn.neg;
    return normalize(add_s(mul_s(a.n, b.d), mul_s(a.d, bn)), mul_s(a.d, b.d));
  endfunction

  function frac_t prod_q(frac_t a, frac_t b);
    return normalize(mul_s(a.n, b.n), mul_s(a.d, b.d));
  endfunction

  function bit [31:0] to_num(smag_t v);
    bit [63:0] w;
    w = v.neg ? (64'd0 - v.mag) : v.mag;
    return w[31:0];
  endfunction

  // Note an accepted operand pair and queue its expected result
  function void note_operands(gra_pkg::in_t x);
    frac_t ar, ai, br, bi, rr, ri, p1, p2, p3, p4;
    gra_pkg::out_t e;
    ovf = 0;
    ar.n = split(x.a_re_num); ar.d = split(x.a_re_den);
    ai.n = split(x.a_im_num); ai.d = split(x.a_im_den);
    br.n = split(x.b_re_num); br.d = split(x.b_re_den);
    bi.n = split(x.b_im_num); bi.d = split(x.b_im_den);
    if (x.op == gra_pkg::OP_ADD || x.op == gra_pkg::OP_SUB) begin
      rr = sum_q(ar, br, x.op == gra_pkg::OP_SUB);
      ri = sum_q(ai, bi, x.op == gra_pkg::OP_SUB);
    end else begin
      p1 = prod_q(ar, br);
      p2 = prod_q(ai, bi);
      p3 = prod_q(ar, bi);
      p4 = prod_q(ai, br);
      rr = sum_q(p1, p2, 1);
      ri = sum_q(p3, p4, 0);
    end
    e.res_re_num = to_num(rr.n);
    e.res_re_den = rr.d.mag[30:0];
    e.res_im_num = to_num(ri.n);
    e.res_im_den = ri.d.mag[30:0];
    e.overflow   = ovf;
    pending.push_back(e);
  endfunction

  // Compare a result with the oldest expectation
  function void check_result(gra_pkg::out_t a);
    gra_pkg::out_t e;
    if (pending.size() == 0) begin
      $error("unexpected result %h", a);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (a.res_re_num !== e.res_re_num) begin
      $error("res_re_num expected %0d actual %0d", e.res_re_num, a.res_re_num);
      errors++;
    end
    if (a.res_re_den !== e.res_re_den) begin
      $error("res_re_den expected %0d actual %0d", e.res_re_den, a.res_re_den);
      errors++;
    end
    if (a.res_im_num !== e.res_im_num) begin
      $error("res_im_num expected %0d actual %0d", e.res_im_num, a.res_im_num);
      errors++;
    end
    if (a.res_im_den !== e.res_im_den) begin
      $error("res_im_den expected %0d actual %0d", e.res_im_den, a.res_im_den);
      errors++;
    end
    if (a.overflow !== e.overflow) begin
      $error("overflow expected %0d actual %0d", e.overflow, a.overflow);
      errors++;
    end
  endfunction
endclass

module tb;
  logic          clk = 0;
  logic          rst_n = 0;
  logic          in_valid = 0;
  logic          in_ready;
  gra_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 0;
  gra_pkg::out_t out_data;

  gra_scoreboard sb = new();
  gra_pkg::in_t  items[$];
  bit            feed_done = 0;

  gaussian_rational_alu dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // Pick a part value: mostly small, sometimes extreme or fully random
  function automatic bit [31:0] pick_part();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'd0;
      4: return 32'hFFFF_FFFF;
      5: return $urandom_range(0, 65535) - 32768;
      default: return $urandom_range(0, 40) - 20;
    endcase
  endfunction

  function automatic gra_pkg::in_t rand_item();
    gra_pkg::in_t x;
    x.op = 2'($urandom_range(0, 3));
    x.a_re_num = pick_part(); x.a_re_den = pick_part();
    x.a_im_num = pick_part(); x.a_im_den = pick_part();
    x.b_re_num = pick_part(); x.b_re_den = pick_part();
    x.b_im_num = pick_part(); x.b_im_den = pick_part();
    return x;
  endfunction

  function automatic gra_pkg::in_t mk(logic [1:0] op, int an, int ad, int bn, int bd);
    gra_pkg::in_t x;
    x.op = op;
    x.a_re_num = an; x.a_re_den = ad; x.a_im_num = bn; x.a_im_den = bd;
    x.b_re_num = bn; x.b_re_den = bd; x.b_im_num = an; x.b_im_den = ad;
    return x;
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send(gra_pkg::in_t x);
    in_valid <= 1;
    in_data  <= x;
    do @(posedge clk); while (!in_ready);
    sb.note_operands(x);
  endtask

  // Sender: bursts of random length with random gaps
  initial begin
    int burst;
    int gap;
    gra_pkg::in_t x;
    items.push_back(mk(gra_pkg::OP_ADD, 1, 2, 1, 3));
    items.push_back(mk(gra_pkg::OP_SUB, 1, 2, 1, 2));
    items.push_back(mk(gra_pkg::OP_MUL, 3, 4, -2, 5));
    items.push_back(mk(gra_pkg::OP_ADD, 0, 7, 0, 9));
    items.push_back(mk(gra_pkg::OP_ADD, 5, 0, 3, 0));
    items.push_back(mk(gra_pkg::OP_SUB, -5, 0, 0, 4));
    items.push_back(mk(gra_pkg::OP_ADD, 0, 0, 0, 0));
    items.push_back(mk(gra_pkg::OP_MUL, 0, 0, 1, 0));
    items.push_back(mk(gra_pkg::OP_MUL, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1));
    items.push_back(mk(gra_pkg::OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, -1));
    items.push_back(mk(gra_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000, -1, -1));
    items.push_back(mk(gra_pkg::OP_SUB, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h7FFF_FFFF));
    items.push_back(mk(gra_pkg::OP_ADD, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFE));
    items.push_back(mk(2'd3, 6, -4, -9, 12));
    items.push_back(mk(gra_pkg::OP_MUL, -1, -1, -1, -1));
    items.push_back(mk(gra_pkg::OP_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 3));
    for (int i = 0; i < 900; i++) items.push_back(rand_item());
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    while (items.size() > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && items.size() > 0) begin
        x = items.pop_front();
        send(x);
        burst--;
      end
      // drop valid only when a real gap follows
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 0;
    feed_done = 1;
  end

  // Receiver: own stall pattern, with one long hold-off early in the run
  initial begin
    int phase;
    phase = 0;
    @(posedge rst_n);
    repeat (3000) @(posedge clk);
    out_ready <= 0;
    repeat (20000) @(posedge clk);
    forever begin
      @(posedge clk);
      phase++;
      if (phase % 4000 < 1500) out_ready <= 1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Drain and report
  initial begin
    wait (feed_done);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit
  initial begin
    #200ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
